// ===== src/hcle_pkg.sv =====
package hcle_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_PARSE_ERROR  = 2'd1;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

  localparam logic [31:0] MAX_BODY_RESET = 32'd2097152;

  // Characters the parser reacts to.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  localparam logic [3:0] KEY_LEN  = 4'd14;
  localparam logic [3:0] KEY_SAT  = 4'd15;

  // One result item as it waits in the output or skid register.
  typedef struct packed {
    logic [31:0] length;
    logic [1:0]  status;
    logic        headers_complete;
  } result_t;

  // Lower-case header name "content-length", one character per position.
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== src/http_content_length_extractor.sv =====
// Content-Length header extractor for an HTTP message stream.
//
// The input channel (in_valid / in_ready) carries one message byte per item,
// with end_of_message marking the final byte of the message. The output
// channel (out_valid / out_ready) carries one result item per message: the
// parsed length, a status code and whether a blank line ended the headers.
// The result appears on the item that holds the blank line, or on the final
// byte when no blank line came; bytes after the blank line are dropped.
// max_body is written through max_body_we / max_body_wdata between messages.
//
// Each byte is parsed in the cycle it is accepted; its result is registered in
// the output register, or in the skid register behind it. One byte is taken
// every cycle while the skid is empty. Throughput is set by the digit step
// (a times-ten add on the 64-bit accumulator) and the end-of-line compare.
//
// A two-entry output (result register plus skid register) lets the parser
// keep taking bytes while a result waits. in_ready only drops while the skid
// register is full, which needs the receiver to stall across two results.
// Synchronous reset clears the parser to the start of a message, empties
// both output registers and restores max_body to 2097152.
module http_content_length_extractor
  import hcle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] length,
  output logic [1:0]  status,
  output logic        headers_complete,
  input  logic        max_body_we,
  input  logic [31:0] max_body_wdata
);

  // Message phase codes.
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_KEY   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // Value parser phase codes.
  localparam logic [1:0] VP_WS     = 2'd0;
  localparam logic [1:0] VP_SIGN   = 2'd1;
  localparam logic [1:0] VP_DIGITS = 2'd2;
  localparam logic [1:0] VP_STOP   = 2'd3;

  logic [31:0] max_body;

  logic [1:0]  phase, phase_next;
  logic [3:0]  key_position, key_position_next;
  logic        key_matches, key_matches_next;
  logic        key_space, key_space_next;
  logic        line_has_chars, line_has_chars_next;
  logic        held_cr, held_cr_next;
  logic [1:0]  value_phase, value_phase_next;
  logic        negative, negative_next;
  logic        digit_seen, digit_seen_next;
  logic [63:0] accumulator, accumulator_next;
  logic        overflowed, overflowed_next;
  logic [31:0] best_length, best_length_next;
  logic [1:0]  best_status, best_status_next;

  result_t     skid;
  logic        skid_valid;

  logic        accept;
  logic        pop;
  logic        in_line;
  logic        is_cr, is_lf;
  logic        line_cr, line_b, line_end, blank;
  logic        eval_line;
  logic        emit;
  result_t     res;

  logic [7:0]  lc;
  logic        is_digit, is_ws;
  logic        b_done;
  logic [67:0] acc_step;
  logic [63:0] value_abs;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  assign in_line = (phase == PH_KEY) || (phase == PH_VALUE);
  assign is_cr   = (byte_in == CH_CR);
  assign is_lf   = (byte_in == CH_LF);

  // A held CR that is not followed by LF turns into an ordinary line byte,
  // ahead of the current byte when that is not a CR itself.
  assign line_cr  = accept && in_line && held_cr && !is_lf;
  assign line_b   = accept && in_line && !is_cr && !is_lf;
  assign blank    = accept && in_line && is_lf && (phase == PH_KEY) && !line_has_chars;
  assign line_end = accept && in_line && is_lf && !blank;

  assign lc       = (byte_in >= CH_UP_A && byte_in <= CH_UP_Z) ? byte_in + 8'd32 : byte_in;
  assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign is_ws    = (byte_in == CH_SPACE) || (byte_in >= CH_TAB && byte_in <= CH_CR);

  always_comb begin
    phase_next          = phase;
    key_position_next   = key_position;
    key_matches_next    = key_matches;
    key_space_next      = key_space;
    line_has_chars_next = line_has_chars;
    held_cr_next        = held_cr;
    value_phase_next    = value_phase;
    negative_next       = negative;
    digit_seen_next     = digit_seen;
    accumulator_next    = accumulator;
    overflowed_next     = overflowed;
    best_length_next    = best_length;
    best_status_next    = best_status;
    emit                = 1'b0;
    res                 = '0;
    b_done              = 1'b0;
    acc_step            = '0;
    value_abs           = '0;
    eval_line           = 1'b0;

    if (accept && phase == PH_FIRST && is_lf) begin
      phase_next = PH_KEY;
    end

    // CR as a line byte: it never matches the key and ends any number.
    if (line_cr) begin
      line_has_chars_next = 1'b1;
      if (phase == PH_KEY) begin
        key_matches_next = 1'b0;
        if (key_position != KEY_SAT) begin
          key_position_next = key_position + 4'd1;
        end
      end else if (value_phase_next == VP_SIGN || value_phase_next == VP_DIGITS) begin
        value_phase_next = VP_STOP;
      end
    end

    if (line_b) begin
      line_has_chars_next = 1'b1;
      if (phase == PH_KEY) begin
        if (byte_in == CH_COLON) begin
          key_matches_next = key_matches_next && (key_position_next == KEY_LEN);
          phase_next       = PH_VALUE;
        end else if (byte_in == CH_SPACE) begin
          key_space_next = 1'b1;
        end else begin
          if (key_space_next || key_position_next >= KEY_LEN ||
              lc != key_char(key_position_next)) begin
            key_matches_next = 1'b0;
          end
          if (key_position_next != KEY_SAT) begin
            key_position_next = key_position_next + 4'd1;
          end
        end
      end else begin
        if (value_phase_next == VP_WS) begin
          if (is_ws) begin
            b_done = 1'b1;
          end else begin
            value_phase_next = VP_SIGN;
            if (byte_in == CH_PLUS || byte_in == CH_MINUS) begin
              negative_next = (byte_in == CH_MINUS);
              b_done        = 1'b1;
            end
          end
        end
        if (!b_done && (value_phase_next == VP_SIGN || value_phase_next == VP_DIGITS)) begin
          if (is_digit) begin
            acc_step = ({4'b0, accumulator_next} << 3) + ({4'b0, accumulator_next} << 1)
                     + {64'b0, byte_in[3:0]};
            if (acc_step[67:64] != 4'b0) begin
              overflowed_next = 1'b1;
            end
            accumulator_next = acc_step[63:0];
            digit_seen_next  = 1'b1;
            value_phase_next = VP_DIGITS;
          end else begin
            value_phase_next = VP_STOP;
          end
        end
      end
    end

    if (accept && in_line) begin
      if (is_cr) begin
        held_cr_next = 1'b1;
      end else begin
        held_cr_next = 1'b0;
      end
    end

    // A line closes at LF, or at the final byte of the message.
    eval_line = line_end ||
                (accept && end_of_message && !blank &&
                 (phase_next == PH_KEY || phase_next == PH_VALUE));
    if (eval_line && phase_next == PH_VALUE && key_matches_next) begin
      value_abs = negative_next ? (64'd0 - accumulator_next) : accumulator_next;
      if (!digit_seen_next || overflowed_next) begin
        best_status_next = ST_PARSE_ERROR;
        best_length_next = '0;
      end else if (value_abs[63:32] != 32'd0 || value_abs[31:0] > max_body) begin
        best_status_next = ST_OUT_OF_RANGE;
        best_length_next = '0;
      end else begin
        best_status_next = ST_OK;
        best_length_next = value_abs[31:0];
      end
    end

    if (line_end) begin
      phase_next          = PH_KEY;
      key_position_next   = '0;
      key_matches_next    = 1'b1;
      key_space_next      = 1'b0;
      line_has_chars_next = 1'b0;
      held_cr_next        = 1'b0;
      value_phase_next    = VP_WS;
      negative_next       = 1'b0;
      digit_seen_next     = 1'b0;
      accumulator_next    = '0;
      overflowed_next     = 1'b0;
    end

    if (blank) begin
      phase_next           = PH_DONE;
      emit                 = 1'b1;
      res.headers_complete = 1'b1;
    end else if (accept && end_of_message && phase != PH_DONE) begin
      emit                 = 1'b1;
      res.headers_complete = 1'b0;
    end
    res.length = best_length_next;
    res.status = best_status_next;

    // The final byte returns the parser to the start of a new message.
    if (accept && end_of_message) begin
      phase_next          = PH_FIRST;
      key_position_next   = '0;
      key_matches_next    = 1'b1;
      key_space_next      = 1'b0;
      line_has_chars_next = 1'b0;
      held_cr_next        = 1'b0;
      value_phase_next    = VP_WS;
      negative_next       = 1'b0;
      digit_seen_next     = 1'b0;
      accumulator_next    = '0;
      overflowed_next     = 1'b0;
      best_length_next    = '0;
      best_status_next    = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body       <= MAX_BODY_RESET;
      phase          <= PH_FIRST;
      key_position   <= '0;
      key_matches    <= 1'b1;
      key_space      <= 1'b0;
      line_has_chars <= 1'b0;
      held_cr        <= 1'b0;
      value_phase    <= VP_WS;
      negative       <= 1'b0;
      digit_seen     <= 1'b0;
      accumulator    <= '0;
      overflowed     <= 1'b0;
      best_length    <= '0;
      best_status    <= ST_OK;
    end else begin
      if (max_body_we) begin
        max_body <= max_body_wdata;
      end
      phase          <= phase_next;
      key_position   <= key_position_next;
      key_matches    <= key_matches_next;
      key_space      <= key_space_next;
      line_has_chars <= line_has_chars_next;
      held_cr        <= held_cr_next;
      value_phase    <= value_phase_next;
      negative       <= negative_next;
      digit_seen     <= digit_seen_next;
      accumulator    <= accumulator_next;
      overflowed     <= overflowed_next;
      best_length    <= best_length_next;
      best_status    <= best_status_next;
    end
  end

  // Output register with a skid register behind it. The skid register only
  // fills when a new result arrives while the output register is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (emit) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        length           <= skid.length;
        status           <= skid.status;
        headers_complete <= skid.headers_complete;
      end
    end else if (emit) begin
      if (!out_valid || pop) begin
        length           <= res.length;
        status           <= res.status;
        headers_complete <= res.headers_complete;
      end else begin
        skid <= res;
      end
    end
  end

  // The skid register is only ever filled behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  // After the final byte of a message the parser is back at the first line.
  a_eom_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_message) |=> (phase == PH_FIRST && !held_cr && best_status == ST_OK))
    else $error("parser did not restart after the end of a message");

  // A failed parse always reports a zero length.
  a_error_zero_length: assert property (@(posedge clk) disable iff (rst)
    emit |-> (res.status == ST_OK || res.length == 32'd0))
    else $error("non-zero length reported with an error status");

  // Blank-line results only come out of header parsing.
  a_blank_from_headers: assert property (@(posedge clk) disable iff (rst)
    (emit && res.headers_complete) |-> (phase == PH_KEY && is_lf))
    else $error("headers_complete result without a blank line");

endmodule

// ===== bench/http_content_length_extractor_tb.sv =====
module http_content_length_extractor_tb;
  import hcle_pkg::*;

  // The run ends here if the block stops making progress.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles allowed after the last result, to catch a late or extra item.
  localparam int SETTLE_CYCLES = 4;
  // Bytes of random stimulus sent under each max_body setting.
  localparam int BYTES_PER_SETTING = 170;
  localparam int SETTING_COUNT = 8;

  localparam logic [63:0] ALL_ONES_64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [8*14-1:0] KEY_TEXT = "content-length";
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  // Where the parser stands within the message and within a header value.
  typedef enum logic [1:0] {P_FIRST, P_KEY, P_VALUE, P_DONE} line_phase_e;
  typedef enum logic [1:0] {V_SPACE, V_SIGN, V_DIGITS, V_STOP} num_phase_e;

  // One row of the directed stimulus table. When typed is set, want holds the
  // result item that the row must produce, written out by hand.
  typedef struct packed {
    logic [7:0] b;
    logic       is_last;
    logic       typed;
    result_t    want;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_in = 8'h00;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] res_length;
  logic [1:0]  res_status;
  logic        res_headers_complete;
  logic        max_body_we = 1'b0;
  logic [31:0] max_body_wdata = 32'd0;

  int cycle_count = 0;
  int errors = 0;

  // Result items that the bench has predicted and the block has not yet sent.
  result_t awaited_results[$];

  // Shadow copy of the block's state, updated once per accepted byte.
  logic [31:0] limit_q;
  line_phase_e ph;
  num_phase_e  num_ph;
  logic [3:0]  kpos;
  bit          kmatch;
  bit          kspace;
  bit          has_chars;
  bit          cr_held;
  bit          neg;
  bit          got_digit;
  bit          ovf;
  logic [63:0] acc;
  logic [31:0] len_best;
  logic [1:0]  st_best;
  bit          sent;

  // Sender burst bookkeeping and the bytes of the message being built.
  int          burst_left = 0;
  logic [7:0]  msg[$];
  stim_row_t   script[$];

  http_content_length_extractor dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .byte_in          (byte_in),
    .end_of_message   (end_of_message),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .length           (res_length),
    .status           (res_status),
    .headers_complete (res_headers_complete),
    .max_body_we      (max_body_we),
    .max_body_wdata   (max_body_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction of the parser.
  // ---------------------------------------------------------------------------

  function automatic void clear_line();
    kpos = '0;
    kmatch = 1'b1;
    kspace = 1'b0;
    has_chars = 1'b0;
    cr_held = 1'b0;
    num_ph = V_SPACE;
    neg = 1'b0;
    got_digit = 1'b0;
    acc = '0;
    ovf = 1'b0;
  endfunction

  function automatic void clear_message();
    ph = P_FIRST;
    clear_line();
    len_best = '0;
    st_best = ST_OK;
    sent = 1'b0;
  endfunction

  // Value bytes work like strtoul: skip white space, take one sign, then read
  // digits until the first byte that is not one.
  function automatic void value_char(input logic [7:0] c);
    logic [63:0] d;
    if (num_ph == V_SPACE) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
      num_ph = V_SIGN;
      if (c == CH_PLUS || c == CH_MINUS) begin
        neg = (c == CH_MINUS);
        return;
      end
    end
    if (num_ph == V_SIGN || num_ph == V_DIGITS) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = {56'd0, c - CH_ZERO};
        if (acc > (ALL_ONES_64 - d) / 64'd10) ovf = 1'b1;
        acc = acc * 64'd10 + d;
        got_digit = 1'b1;
        num_ph = V_DIGITS;
      end else begin
        num_ph = V_STOP;
      end
    end
  endfunction

  // A byte of a header line, after the CR in front of LF has been removed.
  function automatic void line_char(input logic [7:0] c);
    logic [7:0] lc;
    int k;
    has_chars = 1'b1;
    if (ph == P_KEY) begin
      if (c == CH_COLON) begin
        kmatch = kmatch && (kpos == KEY_LEN);
        ph = P_VALUE;
      end else if (c == CH_SPACE) begin
        kspace = 1'b1;
      end else begin
        lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
        k = int'(kpos);
        // A space followed by more key text makes the key a different name.
        if (kspace) kmatch = 1'b0;
        if (kpos >= KEY_LEN) begin
          kmatch = 1'b0;
        end else if (lc != KEY_TEXT[8*(int'(KEY_LEN) - 1 - k) +: 8]) begin
          kmatch = 1'b0;
        end
        if (kpos < KEY_SAT) kpos = kpos + 4'd1;
      end
    end else if (ph == P_VALUE) begin
      value_char(c);
    end
  endfunction

  // The end of a header line. A matching key replaces whatever an earlier
  // matching header left behind.
  function automatic void close_line();
    logic [63:0] v;
    if (ph == P_VALUE && kmatch) begin
      if (!got_digit || ovf) begin
        st_best = ST_PARSE_ERROR;
        len_best = '0;
      end else begin
        v = neg ? (64'd0 - acc) : acc;
        if (v > {32'd0, limit_q}) begin
          st_best = ST_OUT_OF_RANGE;
          len_best = '0;
        end else begin
          st_best = ST_OK;
          len_best = v[31:0];
        end
      end
    end
    ph = P_KEY;
    clear_line();
  endfunction

  // Advances the shadow state by one accepted byte and tells whether the byte
  // produces a result item, and which one.
  function automatic void parse_header_byte(input logic [7:0] b, input bit is_last,
                                            output bit has, output result_t r);
    has = 1'b0;
    r = '0;
    if (ph == P_FIRST) begin
      if (b == CH_LF) begin
        ph = P_KEY;
        clear_line();
      end
    end else if (ph == P_KEY || ph == P_VALUE) begin
      if (b == CH_CR) begin
        // A CR is held back; it only becomes a line byte if no LF follows.
        if (cr_held) line_char(CH_CR);
        cr_held = 1'b1;
      end else if (b == CH_LF) begin
        cr_held = 1'b0;
        if (ph == P_KEY && !has_chars) begin
          has = 1'b1;
          r.length = len_best;
          r.status = st_best;
          r.headers_complete = 1'b1;
          sent = 1'b1;
          ph = P_DONE;
        end else begin
          close_line();
        end
      end else begin
        if (cr_held) begin
          cr_held = 1'b0;
          line_char(CH_CR);
        end
        line_char(b);
      end
    end
    // The final byte flushes an unterminated line and reports, unless the
    // blank line already did.
    if (is_last) begin
      if (!sent) begin
        if (ph == P_KEY || ph == P_VALUE) close_line();
        has = 1'b1;
        r.length = len_best;
        r.status = st_best;
        r.headers_complete = 1'b0;
      end
      clear_message();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving the input channel.
  // ---------------------------------------------------------------------------

  // Sends one byte item. The sender works in bursts; when a burst runs out it
  // may drop valid for a random gap before the next one starts. Every accepted
  // byte goes through the predictor, and a typed row overrides its result.
  task automatic send_byte(input logic [7:0] b, input bit is_last, input bit typed,
                           input result_t want);
    int gap;
    bit has;
    result_t got;
    if (burst_left == 0) begin
      if ($urandom_range(0, 15) == 0) begin
        burst_left = 300;
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    byte_in <= b;
    end_of_message <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_header_byte(b, is_last, has, got);
    if (typed) begin
      awaited_results.push_back(want);
    end else if (has) begin
      awaited_results.push_back(got);
    end
  endtask

  // Lets the block finish: no byte offered, every predicted item received,
  // and a settling wait for a byte that produced nothing.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_body(input logic [31:0] v);
    max_body_we <= 1'b1;
    max_body_wdata <= v;
    @(posedge clk);
    max_body_we <= 1'b0;
    limit_q = v;
  endtask

  task automatic add_row(input logic [7:0] b, input bit is_last, input bit typed,
                         input logic [31:0] len, input logic [1:0] st, input bit hc);
    stim_row_t row;
    row.b = b;
    row.is_last = is_last;
    row.typed = typed;
    row.want.length = len;
    row.want.status = st;
    row.want.headers_complete = hc;
    script.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Building random messages.
  // ---------------------------------------------------------------------------

  // Any byte except LF, so that it stays within the current line.
  function automatic logic [7:0] line_byte_rand();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == CH_LF) b = CH_SPACE;
    return b;
  endfunction

  // A line ends in LF, in CR LF, or in a stray CR followed by CR LF.
  task automatic push_eol();
    case ($urandom_range(0, 5))
      0, 5: msg.push_back(CH_LF);
      4: begin
        msg.push_back(CH_CR);
        msg.push_back(CH_CR);
        msg.push_back(CH_LF);
      end
      default: begin
        msg.push_back(CH_CR);
        msg.push_back(CH_LF);
      end
    endcase
  endtask

  task automatic push_decimal(input logic [63:0] v);
    logic [7:0] digs[$];
    logic [63:0] d;
    do begin
      d = v % 64'd10;
      digs.push_front(CH_ZERO + d[7:0]);
      v = v / 64'd10;
    end while (v != 0);
    foreach (digs[i]) msg.push_back(digs[i]);
  endtask

  // A content-length header in mixed case. Now and then the key is spoiled by
  // a wrong letter, a space inside it, a missing letter or an extra one. The
  // value aims at the interesting numbers: around max_body, at the 32-bit and
  // 64-bit limits, past the 64-bit limit, or no digits at all.
  task automatic push_length_header();
    int i;
    int pos;
    int spoil;
    logic [7:0] c;
    logic [63:0] v;
    pos = $urandom_range(0, 13);
    spoil = $urandom_range(0, 7);
    for (i = 0; i < 14; i++) begin
      c = KEY_TEXT[8*(13 - i) +: 8];
      if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) c = c - 8'd32;
      if (spoil == 0 && i == pos) c = 8'($urandom_range(8'h61, 8'h7A));
      if (spoil == 1 && i == pos) msg.push_back(CH_SPACE);
      if (!(spoil == 2 && i == 13)) msg.push_back(c);
    end
    if (spoil == 3) msg.push_back(8'h73);
    repeat ($urandom_range(0, 2)) msg.push_back(CH_SPACE);
    msg.push_back(CH_COLON);
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 5))
        0: msg.push_back(CH_TAB);
        1: msg.push_back(CH_VT);
        2: msg.push_back(CH_FF);
        3: msg.push_back(CH_CR);
        default: msg.push_back(CH_SPACE);
      endcase
    end
    case ($urandom_range(0, 3))
      2: msg.push_back(CH_PLUS);
      3: msg.push_back(CH_MINUS);
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) msg.push_back(CH_ZERO);
    end
    case ($urandom_range(0, 10))
      0: ;
      1: push_decimal($urandom_range(0, 999));
      2: push_decimal({32'd0, limit_q});
      3: push_decimal({32'd0, limit_q} + 64'd1);
      4: push_decimal({32'd0, limit_q} - 64'd1);
      5: begin
        v = '0;
        v[31:0] = $urandom;
        push_decimal(v);
      end
      6: push_decimal(ALL_ONES_64);
      7: begin
        v[63:32] = $urandom;
        v[31:0] = $urandom;
        push_decimal(v);
      end
      8: begin
        // 2^64 and just above: the overflow shows up on the very last digit.
        push_decimal(64'd1844674407370955161);
        c = CH_ZERO + 8'($urandom_range(6, 9));
        msg.push_back(c);
      end
      9: push_decimal(64'h1_0000_0000);
      default: begin
        repeat ($urandom_range(21, 24)) begin
          c = CH_ZERO + 8'($urandom_range(1, 9));
          msg.push_back(c);
        end
      end
    endcase
    repeat ($urandom_range(0, 2)) msg.push_back(line_byte_rand());
  endtask

  task automatic push_other_header();
    logic [7:0] c;
    repeat ($urandom_range(1, 8)) begin
      c = ($urandom_range(0, 7) == 0) ? CH_MINUS : 8'($urandom_range(8'h41, 8'h5A));
      if ($urandom_range(0, 1) == 1) c = c | 8'h20;
      msg.push_back(c);
    end
    if ($urandom_range(0, 3) == 0) msg.push_back(CH_SPACE);
    msg.push_back(CH_COLON);
    repeat ($urandom_range(0, 6)) msg.push_back(line_byte_rand());
  endtask

  // A printable line with no colon, which the parser must ignore.
  task automatic push_plain_line();
    logic [7:0] c;
    repeat ($urandom_range(1, 10)) begin
      c = 8'($urandom_range(8'h20, 8'h7E));
      if (c == CH_COLON) c = 8'h78;
      msg.push_back(c);
    end
  endtask

  task automatic build_message();
    int kind;
    int k;
    logic [7:0] c;
    msg.delete();
    repeat ($urandom_range(0, 6)) msg.push_back(line_byte_rand());
    // Now and then the message stops inside the request line.
    if ($urandom_range(0, 19) == 0) begin
      if (msg.size() == 0) msg.push_back(8'h47);
      return;
    end
    msg.push_back(CH_LF);
    repeat ($urandom_range(0, 4)) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        push_length_header();
      end else if (kind < 7) begin
        push_other_header();
      end else if (kind < 8) begin
        push_plain_line();
      end else begin
        repeat ($urandom_range(1, 10)) msg.push_back(line_byte_rand());
      end
      push_eol();
    end
    case ($urandom_range(0, 9))
      0: ;
      1: begin
        // Cut the message short, usually in the middle of a line.
        k = $urandom_range(1, 6);
        while (k > 0 && msg.size() > 1) begin
          void'(msg.pop_back());
          k--;
        end
      end
      default: begin
        push_eol();
        // Bytes after the blank line are dropped by the block.
        repeat ($urandom_range(0, 3)) begin
          c = 8'($urandom);
          msg.push_back(c);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: out_ready follows a pattern that changes from time to time,
  // from always ready to long stalls that fill the block's output registers
  // and push back on the input side.
  // ---------------------------------------------------------------------------

  int ready_mode = 0;
  int ready_hold = 0;

  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_hold <= $urandom_range(20, 200);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= (cycle_count % 7 == 0);
      default: out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checking: every accepted result item is compared with the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result item: expected none, actual length %0d status %0d "
                 , $time, res_length, res_status,
                 "headers_complete %0d", res_headers_complete);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (res_length !== want.length) begin
          $display("%0t: length mismatch: expected %0d, actual %0d",
                   $time, want.length, res_length);
          errors++;
        end
        if (res_status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, res_status);
          errors++;
        end
        if (res_headers_complete !== want.headers_complete) begin
          $display("%0t: headers_complete mismatch: expected %0d, actual %0d",
                   $time, want.headers_complete, res_headers_complete);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("http_content_length_extractor test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------

  initial begin
    string key_colon;
    int setting;
    int sent_bytes;
    int i;
    logic [31:0] new_limit;

    limit_q = MAX_BODY_RESET;
    clear_message();

    // Directed table. Each message ends on a byte with end_of_message set.
    // A bare blank line right after the request line reports nothing found,
    // with the headers complete.
    add_row(CH_LF, 1'b0, 1'b0, 32'd0, ST_OK, 1'b0);
    add_row(CH_LF, 1'b1, 1'b1, 32'd0, ST_OK, 1'b1);
    // A message that is one byte long ends inside the request line.
    add_row(8'hFF, 1'b1, 1'b1, 32'd0, ST_OK, 1'b0);
    // A CR as the very last byte is dropped; the headers never completed.
    add_row(8'h00, 1'b0, 1'b0, 32'd0, ST_OK, 1'b0);
    add_row(CH_LF, 1'b0, 1'b0, 32'd0, ST_OK, 1'b0);
    add_row(CH_CR, 1'b1, 1'b1, 32'd0, ST_OK, 1'b0);
    // A matching key in mixed case with an empty value is a parse error.
    add_row(CH_LF, 1'b0, 1'b0, 32'd0, ST_OK, 1'b0);
    key_colon = "Content-Length:";
    for (i = 0; i < key_colon.len(); i++) add_row(key_colon[i], 1'b0, 1'b0, 32'd0, ST_OK, 1'b0);
    add_row(CH_CR, 1'b0, 1'b0, 32'd0, ST_OK, 1'b0);
    add_row(CH_LF, 1'b0, 1'b0, 32'd0, ST_OK, 1'b0);
    add_row(CH_LF, 1'b1, 1'b1, 32'd0, ST_PARSE_ERROR, 1'b1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[j]) begin
      send_byte(script[j].b, script[j].is_last, script[j].typed, script[j].want);
    end

    // Random messages under a series of max_body settings. The first setting
    // is the reset value; the extremes come next.
    for (setting = 0; setting < SETTING_COUNT; setting++) begin
      if (setting > 0) begin
        case (setting)
          1: new_limit = 32'd0;
          2: new_limit = 32'hFFFF_FFFF;
          3: new_limit = $urandom_range(0, 999);
          4: new_limit = MAX_BODY_RESET;
          5: new_limit = $urandom_range(0, 65535);
          default: new_limit = $urandom;
        endcase
        wait_idle();
        write_max_body(new_limit);
      end
      sent_bytes = 0;
      while (sent_bytes < BYTES_PER_SETTING) begin
        build_message();
        for (i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1, 1'b0, '0);
        sent_bytes += msg.size();
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("http_content_length_extractor test passed");
    end else begin
      $display("http_content_length_extractor test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/hcle_pkg.sv
src/http_content_length_extractor.sv
bench/http_content_length_extractor_tb.sv
